// ===== hw/rtl/cats_pkg.sv =====
// Package for the counter-aging task selector: sizes, codes and slot entry type.
package cats_pkg;

    localparam int TASKS = 64;
    localparam int IDX_W = $clog2(TASKS);
    localparam int CNT_W = 16;
    localparam int PRI_W = 8;

    localparam logic [IDX_W:0] SCAN_END = (IDX_W + 1)'(TASKS);

    typedef enum logic [1:0] {
        MODE_WRITE  = 2'd0,
        MODE_YIELD  = 2'd1,
        MODE_EXIT   = 2'd2,
        MODE_SELECT = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        SLOT_EMPTY   = 2'd0,
        SLOT_RUNNING = 2'd1,
        SLOT_WAITING = 2'd2,
        SLOT_ZOMBIE  = 2'd3
    } t_slot_st;

    typedef enum logic [1:0] {
        RES_WRITE    = 2'd0,
        RES_SELECTED = 2'd1,
        RES_NONE     = 2'd2,
        RES_STALLED  = 2'd3
    } t_res_status;

    typedef struct packed {
        t_slot_st          st;
        logic [CNT_W-1:0]  cnt;
        logic [PRI_W-1:0]  pri;
    } t_entry;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_RMW_RD = 6'b000010,
        S_RMW_WR = 6'b000100,
        S_SCAN   = 6'b001000,
        S_DECIDE = 6'b010000,
        S_DONE   = 6'b100000
    } t_state;

endpackage

// ===== hw/rtl/cats_in_if.sv =====
// Request channel interface: one scheduling command word per handshake.
interface cats_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [5:0]  task_index;
    logic [1:0]  task_state;
    logic [15:0] counter_value;
    logic [7:0]  priority_value;

    modport source (
        output valid, mode, task_index, task_state, counter_value, priority_value,
        input  ready
    );
    modport sink (
        input  valid, mode, task_index, task_state, counter_value, priority_value,
        output ready
    );
endinterface

// ===== hw/rtl/cats_out_if.sv =====
// Response channel interface: one result word per handshake.
interface cats_out_if;
    logic       valid;
    logic       ready;
    logic [5:0] next_task;
    logic       switched;
    logic [1:0] status;

    modport source (
        output valid, next_task, switched, status,
        input  ready
    );
    modport sink (
        input  valid, next_task, switched, status,
        output ready
    );
endinterface

// ===== hw/rtl/counter_aging_task_selector.sv =====
// Top level: counter-aging task selector with a sequential slot scan over one memory port.
// A slot write goes straight to the result register; a select scans every slot and then decides,
// with yield/exit first reading and rewriting the current slot, and an aging pass scanning again.
// New words are accepted only in idle; the single slot-memory read port sets the scan length.
// Reset: synchronous, active low; clears control and per-slot valid flags. Unwritten slots
// read as their reset values (slot 0 running, others empty, zero counters), no clearing pass.
module counter_aging_task_selector
    import cats_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    cats_in_if.sink    i_req,
    cats_out_if.source o_rsp
);

    // state and sequencing
    t_state             r_state, n_state;
    t_mode              r_mode, n_mode;
    logic [IDX_W-1:0]   r_cur, n_cur;
    logic [IDX_W:0]     r_addr, n_addr;
    logic               r_rd_vld, n_rd_vld;
    logic               r_aging, n_aging;
    logic               r_found, n_found;
    logic [IDX_W-1:0]   r_best, n_best;
    logic [CNT_W-1:0]   r_bestc, n_bestc;
    logic               r_anyprio, n_anyprio;
    logic [IDX_W-1:0]   r_res_next, n_res_next;
    logic               r_res_sw, n_res_sw;
    t_res_status        r_res_status, n_res_status;
    logic               r_out_valid, n_out_valid;
    logic [IDX_W-1:0]   r_o_next, n_o_next;
    logic               r_o_sw, n_o_sw;
    t_res_status        r_o_status, n_o_status;
    logic [TASKS-1:0]   r_valid, n_valid;

    // slot memory
    t_entry             r_mem [TASKS];
    t_entry             r_rd_data;
    logic               r_rd_ok;
    logic [IDX_W-1:0]   r_rd_idx;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    t_entry             wr_data;

    t_entry             ent;
    logic [CNT_W:0]     age_sum;
    logic [CNT_W-1:0]   aged;
    logic [CNT_W-1:0]   cnt_eff;
    logic               run;
    logic               accept;
    logic [IDX_W-1:0]   pick;

    assign i_req.ready     = (r_state == S_IDLE);
    assign accept          = i_req.valid && i_req.ready;
    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.next_task = r_o_next;
    assign o_rsp.switched  = r_o_sw;
    assign o_rsp.status    = r_o_status;

    assign rd_addr = (r_state == S_RMW_RD) ? r_cur : r_addr[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
        r_rd_ok   <= r_valid[rd_addr];
        r_rd_idx  <= rd_addr;
    end

    // slots never written read as reset contents
    always_comb begin
        if (r_rd_ok) begin
            ent = r_rd_data;
        end else begin
            ent.st  = (r_rd_idx == '0) ? SLOT_RUNNING : SLOT_EMPTY;
            ent.cnt = '0;
            ent.pri = '0;
        end
        age_sum = {2'b00, ent.cnt[CNT_W-1:1]} + (CNT_W + 1)'(ent.pri);
        aged    = age_sum[CNT_W] ? {CNT_W{1'b1}} : age_sum[CNT_W-1:0];
        cnt_eff = r_aging ? aged : ent.cnt;
        run     = (ent.st == SLOT_RUNNING);
    end

    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_cur        = r_cur;
        n_addr       = r_addr;
        n_rd_vld     = 1'b0;
        n_aging      = r_aging;
        n_found      = r_found;
        n_best       = r_best;
        n_bestc      = r_bestc;
        n_anyprio    = r_anyprio;
        n_res_next   = r_res_next;
        n_res_sw     = r_res_sw;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_o_next     = r_o_next;
        n_o_sw       = r_o_sw;
        n_o_status   = r_o_status;
        n_valid      = r_valid;
        wr_en        = 1'b0;
        wr_addr      = r_rd_idx;
        wr_data      = ent;
        pick         = r_cur;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_mode    = t_mode'(i_req.mode);
                    n_addr    = '0;
                    n_aging   = 1'b0;
                    n_found   = 1'b0;
                    n_best    = '0;
                    n_bestc   = '0;
                    n_anyprio = 1'b0;
                    case (t_mode'(i_req.mode))
                        MODE_WRITE: begin
                            if (32'(i_req.task_index) < TASKS) begin
                                wr_en       = 1'b1;
                                wr_addr     = i_req.task_index[IDX_W-1:0];
                                wr_data.st  = t_slot_st'(i_req.task_state);
                                wr_data.cnt = i_req.counter_value;
                                wr_data.pri = i_req.priority_value;
                            end
                            n_res_next   = r_cur;
                            n_res_sw     = 1'b0;
                            n_res_status = RES_WRITE;
                            n_state      = S_DONE;
                        end
                        MODE_YIELD, MODE_EXIT: n_state = S_RMW_RD;
                        default:               n_state = S_SCAN;
                    endcase
                end
            end
            S_RMW_RD: begin
                n_state = S_RMW_WR;
            end
            S_RMW_WR: begin
                wr_en       = 1'b1;
                wr_addr     = r_rd_idx;
                wr_data.st  = (r_mode == MODE_EXIT) ? SLOT_ZOMBIE : ent.st;
                wr_data.cnt = '0;
                wr_data.pri = ent.pri;
                n_state     = S_SCAN;
            end
            S_SCAN: begin
                if (r_addr != SCAN_END) begin
                    n_addr   = r_addr + 1'b1;
                    n_rd_vld = 1'b1;
                end
                if (r_rd_vld) begin
                    if (run && (!r_found || cnt_eff > r_bestc)) begin
                        n_found = 1'b1;
                        n_best  = r_rd_idx;
                        n_bestc = cnt_eff;
                    end
                    if (run && ent.pri != '0) begin
                        n_anyprio = 1'b1;
                    end
                    if (r_aging && ent.st != SLOT_EMPTY) begin
                        wr_en       = 1'b1;
                        wr_addr     = r_rd_idx;
                        wr_data.cnt = aged;
                    end
                end
                if (r_addr == SCAN_END && !r_rd_vld) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_state = S_DONE;
                if (!r_found) begin
                    pick         = '0;
                    n_res_status = RES_NONE;
                end else if (r_bestc != '0 || r_aging) begin
                    pick         = r_best;
                    n_res_status = RES_SELECTED;
                end else if (!r_anyprio) begin
                    pick         = r_cur;
                    n_res_status = RES_STALLED;
                end else begin
                    // every running counter is zero: age non-empty slots and rescan
                    n_aging   = 1'b1;
                    n_addr    = '0;
                    n_found   = 1'b0;
                    n_best    = '0;
                    n_bestc   = '0;
                    n_state   = S_SCAN;
                end
                n_res_next = pick;
                n_res_sw   = (pick != r_cur);
                if (n_state == S_DONE) begin
                    n_cur = pick;
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_o_next    = r_res_next;
                    n_o_sw      = r_res_sw;
                    n_o_status  = r_res_status;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (wr_en) begin
            n_valid[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cur       <= '0;
            r_addr      <= '0;
            r_rd_vld    <= 1'b0;
            r_aging     <= 1'b0;
            r_found     <= 1'b0;
            r_anyprio   <= 1'b0;
            r_out_valid <= 1'b0;
            r_valid     <= '0;
        end else begin
            r_state     <= n_state;
            r_cur       <= n_cur;
            r_addr      <= n_addr;
            r_rd_vld    <= n_rd_vld;
            r_aging     <= n_aging;
            r_found     <= n_found;
            r_anyprio   <= n_anyprio;
            r_out_valid <= n_out_valid;
            r_valid     <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode       <= n_mode;
        r_best       <= n_best;
        r_bestc      <= n_bestc;
        r_res_next   <= n_res_next;
        r_res_sw     <= n_res_sw;
        r_res_status <= n_res_status;
        r_o_next     <= n_o_next;
        r_o_sw       <= n_o_sw;
        r_o_status   <= n_o_status;
    end

endmodule
